// ===== rtl/odq_pkg.sv =====
`timescale 1ns / 1ps
package odq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int OP_W           = 3;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;
  localparam int ENTRY_COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_ADD_FRONT    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_BACK     = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND         = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ===== rtl/odq_req_if.sv =====
`timescale 1ns / 1ps
interface odq_req_if;
  import odq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [OP_W-1:0]    op;
  logic signed [VALUE_W-1:0] item_value;

  modport source (output valid, output op, output item_value, input ready);
  modport sink   (input valid, input op, input item_value, output ready);
endinterface

// ===== rtl/odq_rsp_if.sv =====
`timescale 1ns / 1ps
interface odq_rsp_if;
  import odq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [STATUS_W-1:0]      status;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output found, output status, output entry_count, input ready);
  modport sink   (input valid, input found, input status, input entry_count, output ready);
endinterface

// ===== rtl/odq_ram.sv =====
`timescale 1ns / 1ps
module odq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ordered_list_deque_search_top.sv =====
`timescale 1ns / 1ps
// Channel  Modport   Word
// req      sink      op, item_value
// rsp      source    found, status, entry_count
//
// Add and plain remove words go from idle to S_DONE, where the result is registered into
// the rsp slot once it is free. Find and remove value pass through S_SCAN first: the list is
// walked one entry per cycle through the single read port of the entry RAM, and a delete
// shifts the tail down one place as it is read. Entries sit in the RAM as a ring with a
// head pointer. Reset clears only the head, count and control state. A new word is
// taken while a result still waits on rsp; the next result waits for that slot.
module ordered_list_deque_search_top #(
  parameter int CAPACITY = odq_pkg::CAPACITY_DEF
) (
  input logic         clk,
  input logic         rst,
  odq_req_if.sink     req,
  odq_rsp_if.source   rsp
);
  import odq_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  state_t state, state_next;

  logic [PW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [OP_W-1:0]     op_r, op_r_next;
  logic [VALUE_W-1:0]  value_r, value_r_next;
  logic [CW-1:0]       issue_left, issue_left_next;
  logic [PW-1:0]       rd_ptr, rd_ptr_next;
  logic                arr_valid, arr_valid_next;
  logic [PW-1:0]       arr_ptr, arr_ptr_next;
  logic                arr_last, arr_last_next;
  logic                matched, matched_next;
  logic [PW-1:0]       last_ptr, last_ptr_next;
  logic                pend_found, pend_found_next;
  logic [STATUS_W-1:0] pend_status, pend_status_next;
  logic                res_valid, res_valid_next;
  logic                res_found, res_found_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [ENTRY_COUNT_W-1:0] res_count, res_count_next;

  logic               we;
  logic [PW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [VALUE_W-1:0] rdata;

  logic [SW-1:0] tail_sum;
  logic [PW-1:0] tail_ptr;
  logic [PW-1:0] head_dec;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] rd_ptr_inc;
  logic          hit;
  logic          full;
  logic          empty;

  odq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  assign tail_sum   = SW'(head) + SW'(count);
  assign tail_ptr   = (tail_sum >= SW'(CAPACITY)) ? PW'(tail_sum - SW'(CAPACITY))
                                                  : PW'(tail_sum);
  assign head_dec   = (head == '0) ? PW'(CAPACITY - 1) : head - PW'(1);
  assign head_inc   = (head == PW'(CAPACITY - 1)) ? '0 : head + PW'(1);
  assign rd_ptr_inc = (rd_ptr == PW'(CAPACITY - 1)) ? '0 : rd_ptr + PW'(1);
  assign hit        = (rdata == value_r);
  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = res_valid;
  assign rsp.found       = res_found;
  assign rsp.status      = res_status;
  assign rsp.entry_count = res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      arr_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      arr_valid <= arr_valid_next;
      res_valid <= res_valid_next;
    end
    op_r        <= op_r_next;
    value_r     <= value_r_next;
    issue_left  <= issue_left_next;
    rd_ptr      <= rd_ptr_next;
    arr_ptr     <= arr_ptr_next;
    arr_last    <= arr_last_next;
    matched     <= matched_next;
    last_ptr    <= last_ptr_next;
    pend_found  <= pend_found_next;
    pend_status <= pend_status_next;
    res_found   <= res_found_next;
    res_status  <= res_status_next;
    res_count   <= res_count_next;
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    op_r_next        = op_r;
    value_r_next     = value_r;
    issue_left_next  = issue_left;
    rd_ptr_next      = rd_ptr;
    arr_valid_next   = 1'b0;
    arr_ptr_next     = arr_ptr;
    arr_last_next    = arr_last;
    matched_next     = matched;
    last_ptr_next    = last_ptr;
    pend_found_next  = pend_found;
    pend_status_next = pend_status;
    res_valid_next   = res_valid && !rsp.ready;
    res_found_next   = res_found;
    res_status_next  = res_status;
    res_count_next   = res_count;
    we               = 1'b0;
    waddr            = tail_ptr;
    wdata            = $unsigned(req.item_value);

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_r_next        = req.op;
          value_r_next     = $unsigned(req.item_value);
          pend_found_next  = 1'b0;
          pend_status_next = ST_DONE;
          matched_next     = 1'b0;
          issue_left_next  = count;
          rd_ptr_next      = head;
          state_next       = S_DONE;
          unique case (req.op)
            OP_ADD_FRONT: begin
              if (full) begin
                pend_status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = head_dec;
                head_next  = head_dec;
                count_next = count + CW'(1);
              end
            end
            OP_ADD_BACK: begin
              if (full) begin
                pend_status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_REMOVE_FRONT: begin
              if (empty) begin
                pend_status_next = ST_EMPTY;
              end else begin
                head_next  = head_inc;
                count_next = count - CW'(1);
              end
            end
            OP_REMOVE_BACK: begin
              if (empty) begin
                pend_status_next = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            OP_FIND, OP_REMOVE_VALUE: begin
              if (empty) begin
                pend_status_next = ST_EMPTY;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue_left != '0) begin
          rd_ptr_next     = rd_ptr_inc;
          issue_left_next = issue_left - CW'(1);
          arr_valid_next  = 1'b1;
          arr_ptr_next    = rd_ptr;
          arr_last_next   = (issue_left == CW'(1));
        end
        if (arr_valid) begin
          if (op_r == OP_FIND) begin
            if (hit || arr_last) begin
              pend_found_next = hit;
              state_next      = S_DONE;
              arr_valid_next  = 1'b0;
            end
          end else begin
            // Once the match is seen, every later entry moves down one slot.
            if (matched) begin
              we    = 1'b1;
              waddr = last_ptr;
              wdata = rdata;
            end
            matched_next  = matched || hit;
            last_ptr_next = arr_ptr;
            if (arr_last) begin
              pend_found_next = matched || hit;
              if (matched || hit) begin
                count_next = count - CW'(1);
              end
              state_next     = S_DONE;
              arr_valid_next = 1'b0;
            end
          end
        end
      end

      S_DONE: begin
        if (!res_valid || rsp.ready) begin
          res_valid_next  = 1'b1;
          res_found_next  = pend_found;
          res_status_next = pend_status;
          res_count_next  = ENTRY_COUNT_W'(count);
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
